// File: rtl/core/pes_pkg.sv
// Shared types, constants and helpers for the particle emitter step block.
// No dependencies; every other file in rtl/core imports this package.
package pes_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    localparam logic [2:0] REG_COUNT    = 3'd0;
    localparam logic [2:0] REG_GRAVITY  = 3'd1;
    localparam logic [2:0] REG_LIFETIME = 3'd2;
    localparam logic [2:0] REG_INTERVAL = 3'd3;
    localparam logic [2:0] REG_SCALE    = 3'd4;
    localparam logic [2:0] REG_VEL_X    = 3'd5;
    localparam logic [2:0] REG_VEL_Y    = 3'd6;
    localparam logic [2:0] REG_VEL_Z    = 3'd7;

    typedef struct packed {
        logic [16:0] tick_dt;
        logic [15:0] rand_x;
        logic [15:0] rand_y;
        logic [15:0] rand_z;
    } tick_t;

    typedef struct packed {
        logic [5:0]         slot;
        logic               alive;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        scale_out;
        logic               last_slot;
    } part_t;

    typedef struct packed {
        logic [6:0]  particle_count;
        logic [30:0] gravity_accel;
        logic [30:0] lifetime;
        logic [30:0] spawn_interval;
        logic [30:0] particle_scale;
        logic [31:0] vel_range_x;
        logic [31:0] vel_range_y;
        logic [31:0] vel_range_z;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GRAV, ST_GRAVW, ST_LOAD, ST_SPX, ST_SPY, ST_SPZ, ST_SPW,
        ST_VY, ST_MX, ST_MY, ST_MZ, ST_MW, ST_STORE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_TAKE, OP_GRAV, OP_GRAVW, OP_LOAD, OP_SPX, OP_SPY, OP_SPZ,
        OP_SPW, OP_VY, OP_MX, OP_MY, OP_MZ, OP_MW, OP_STORE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic spawn_hit;
        logic last;
        logic out_free;
    } stat_t;

    function automatic logic signed [31:0] sat_s32(input logic signed [35:0] v);
        if (v[35:31] == {5{v[35]}})
            return v[31:0];
        return v[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    function automatic logic [31:0] sat_u32(input logic [32:0] v);
        return v[32] ? 32'hffff_ffff : v[31:0];
    endfunction

endpackage

// File: rtl/core/particle_emitter_step_top.sv
// Top level of the particle emitter step: configuration registers and glue.
// Depends on pes_pkg, pes_ctrl and pes_datapath.
//
// Use:
//   tick channel (tick_valid/tick_ready/tick_word): one word per time tick,
//   carrying dt and three random fractions for spawn velocities.
//   part channel (part_valid/part_ready/part_word): one word per walked
//   slot, alive or dead, in slot order, last_slot set on the final one.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   write only while no tick is in flight.
// Timing: a tick is taken only while the sequencer is idle. After the take step,
//   gravity*dt is multiplied and written back; then each slot runs load,
//   velocity, three position multiplies, liveness and store, with the spawn
//   velocity multiplies and spawn write inserted after load when it respawns,
//   all through one shared multiplier. With a count of zero the tick is
//   absorbed without a walk.
// Stall: results sit in one output register; while it is full and not
//   taken the walk holds in its store step, so nothing is dropped.
// Reset: all slots dead with zeroed state, spawn timer zero, registers at
//   their documented defaults.
module particle_emitter_step_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick_valid,
    output logic           tick_ready,
    input  pes_pkg::tick_t tick_word,
    output logic           part_valid,
    input  logic           part_ready,
    output pes_pkg::part_t part_word,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import pes_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // register file, fields masked to their widths on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.particle_count <= 7'd5;
            cfg_reg.gravity_accel  <= 31'd642252;
            cfg_reg.lifetime       <= 31'd131072;
            cfg_reg.spawn_interval <= 31'd19661;
            cfg_reg.particle_scale <= 31'd19661;
            cfg_reg.vel_range_x    <= 32'd50396416;
            cfg_reg.vel_range_y    <= 32'd167773440;
            cfg_reg.vel_range_z    <= 32'd50396416;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COUNT:    cfg_reg.particle_count <= cfg_data[6:0];
                REG_GRAVITY:  cfg_reg.gravity_accel  <= cfg_data[30:0];
                REG_LIFETIME: cfg_reg.lifetime       <= cfg_data[30:0];
                REG_INTERVAL: cfg_reg.spawn_interval <= cfg_data[30:0];
                REG_SCALE:    cfg_reg.particle_scale <= cfg_data[30:0];
                REG_VEL_X:    cfg_reg.vel_range_x    <= cfg_data;
                REG_VEL_Y:    cfg_reg.vel_range_y    <= cfg_data;
                REG_VEL_Z:    cfg_reg.vel_range_z    <= cfg_data;
                default: ;
            endcase
        end
    end

    pes_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    pes_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .tick_word  (tick_word),
        .cmd        (cmd),
        .stat       (stat),
        .part_valid (part_valid),
        .part_ready (part_ready),
        .part_word  (part_word)
    );

endmodule

// File: rtl/core/pes_datapath.sv
// Datapath: slot state, shared multiplier, saturating update and result register.
// Depends on pes_pkg; driven by op codes from pes_ctrl.
module pes_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  pes_pkg::cfg_t  cfg,
    input  pes_pkg::tick_t tick_word,
    input  pes_pkg::cmd_t  cmd,
    output pes_pkg::stat_t stat,
    output logic           part_valid,
    input  logic           part_ready,
    output pes_pkg::part_t part_word
);
    import pes_pkg::*;

    logic signed [31:0] pos_reg [MAX_SLOTS][3];
    logic signed [31:0] vel_reg [MAX_SLOTS][3];
    logic [31:0]        age_reg [MAX_SLOTS];
    logic [30:0]        scl_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] live_reg;
    logic [31:0]        since_reg;

    tick_t              tk_reg;
    logic [6:0]         n_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [32:0]        grav_reg;
    logic signed [50:0] prod_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg, vx_reg, vy_reg, vz_reg;
    logic [31:0]        wage_reg;
    logic [30:0]        wscl_reg;
    logic               wlive_reg;

    part_t              out_reg;
    logic               ov_reg;

    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [16:0] span_x, span_y, span_z;
    logic signed [31:0] spawn_v;
    logic signed [35:0] pos_sum;
    logic signed [31:0] pos_sel;
    logic [6:0]         idx_ext;
    logic               is_last;

    function automatic logic signed [16:0] span(input logic [31:0] r);
        return $signed({r[31], r[31:16]}) - $signed({r[15], r[15:0]});
    endfunction

    assign span_x  = span(cfg.vel_range_x);
    assign span_y  = span(cfg.vel_range_y);
    assign span_z  = span(cfg.vel_range_z);
    assign idx_ext = 7'(idx_reg);
    assign is_last = (idx_ext + 7'd1) == n_reg;

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = $signed({1'b0, tk_reg.tick_dt});
        case (cmd.op)
            OP_GRAV: mul_a = $signed({2'b00, cfg.gravity_accel});
            OP_SPX:
            begin
                mul_a = 33'(span_x);
                mul_b = $signed({2'b00, tk_reg.rand_x});
            end
            OP_SPY:
            begin
                mul_a = 33'(span_y);
                mul_b = $signed({2'b00, tk_reg.rand_y});
            end
            OP_SPZ:
            begin
                mul_a = 33'(span_z);
                mul_b = $signed({2'b00, tk_reg.rand_z});
            end
            OP_MX:   mul_a = 33'(vx_reg);
            OP_MY:   mul_a = 33'(vy_reg);
            OP_MZ:   mul_a = 33'(vz_reg);
            default: mul_a = '0;
        endcase
    end

    // spawn velocity of the axis whose product has just landed
    always_comb
    begin
        logic [15:0] lo;
        case (cmd.op)
            OP_SPY:  lo = cfg.vel_range_x[15:0];
            OP_SPZ:  lo = cfg.vel_range_y[15:0];
            default: lo = cfg.vel_range_z[15:0];
        endcase
        spawn_v = $signed({{8{lo[15]}}, lo, 8'h00}) + $signed(prod_reg[39:8]);
    end

    always_comb
    begin
        case (cmd.op)
            OP_MY:   pos_sel = px_reg;
            OP_MZ:   pos_sel = py_reg;
            default: pos_sel = pz_reg;
        endcase
        pos_sum = 36'(pos_sel) + 36'($signed(prod_reg[50:16]));
    end

    assign stat.count_zero = (cfg.particle_count == 7'd0);
    assign stat.spawn_hit  = !live_reg[idx_reg] && (since_reg > {1'b0, cfg.spawn_interval});
    assign stat.last       = is_last;
    assign stat.out_free   = !ov_reg || part_ready;

    always_ff @(posedge clk)
        prod_reg <= mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= '0;
            since_reg <= '0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            for (int s = 0; s < MAX_SLOTS; s++)
            begin
                age_reg[s] <= '0;
                scl_reg[s] <= '0;
                for (int a = 0; a < 3; a++)
                begin
                    pos_reg[s][a] <= '0;
                    vel_reg[s][a] <= '0;
                end
            end
        end
        else
        begin
            if (part_ready)
                ov_reg <= 1'b0;
            case (cmd.op)
                OP_TAKE:
                begin
                    idx_reg <= '0;
                    if (cfg.particle_count == 7'd0)
                        since_reg <= sat_u32({1'b0, since_reg} + 33'(tick_word.tick_dt));
                end
                OP_SPW:  since_reg <= '0;
                OP_STORE:
                begin
                    pos_reg[idx_reg][0] <= px_reg;
                    pos_reg[idx_reg][1] <= py_reg;
                    pos_reg[idx_reg][2] <= pz_reg;
                    vel_reg[idx_reg][0] <= vx_reg;
                    vel_reg[idx_reg][1] <= vy_reg;
                    vel_reg[idx_reg][2] <= vz_reg;
                    age_reg[idx_reg]    <= wage_reg;
                    scl_reg[idx_reg]    <= wscl_reg;
                    live_reg[idx_reg]   <= wlive_reg;
                    ov_reg              <= 1'b1;
                    if (is_last)
                        since_reg <= sat_u32({1'b0, since_reg} + 33'(tk_reg.tick_dt));
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // working copy of the current slot
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_TAKE:
            begin
                tk_reg <= tick_word;
                n_reg  <= (cfg.particle_count > 7'(MAX_SLOTS)) ? 7'(MAX_SLOTS)
                                                               : cfg.particle_count;
            end
            OP_GRAVW: grav_reg <= prod_reg[48:16];
            OP_LOAD:
            begin
                px_reg    <= pos_reg[idx_reg][0];
                py_reg    <= pos_reg[idx_reg][1];
                pz_reg    <= pos_reg[idx_reg][2];
                vx_reg    <= vel_reg[idx_reg][0];
                vy_reg    <= vel_reg[idx_reg][1];
                vz_reg    <= vel_reg[idx_reg][2];
                wage_reg  <= age_reg[idx_reg];
                wscl_reg  <= scl_reg[idx_reg];
                wlive_reg <= live_reg[idx_reg];
            end
            OP_SPY: vx_reg <= spawn_v;
            OP_SPZ: vy_reg <= spawn_v;
            OP_SPW:
            begin
                vz_reg    <= spawn_v;
                px_reg    <= '0;
                py_reg    <= '0;
                pz_reg    <= '0;
                wage_reg  <= '0;
                wscl_reg  <= cfg.particle_scale;
                wlive_reg <= 1'b1;
            end
            OP_VY:
            begin
                wage_reg <= sat_u32({1'b0, wage_reg} + 33'(tk_reg.tick_dt));
                vy_reg   <= sat_s32(36'(vy_reg) - $signed({3'b000, grav_reg}));
            end
            OP_MY: px_reg <= sat_s32(pos_sum);
            OP_MZ: py_reg <= sat_s32(pos_sum);
            OP_MW:
            begin
                pz_reg <= sat_s32(pos_sum);
                if (wage_reg > {1'b0, cfg.lifetime})
                    wlive_reg <= 1'b0;
            end
            OP_STORE:
            begin
                out_reg.slot      <= 6'(idx_reg);
                out_reg.alive     <= wlive_reg;
                out_reg.pos_x     <= px_reg;
                out_reg.pos_y     <= py_reg;
                out_reg.pos_z     <= pz_reg;
                out_reg.scale_out <= wlive_reg ? wscl_reg : 31'd0;
                out_reg.last_slot <= is_last;
            end
            default: ;
        endcase
    end

    assign part_valid = ov_reg;
    assign part_word  = out_reg;

endmodule

// File: rtl/core/pes_ctrl.sv
// Sequencer for the slot walk: one op code per cycle to the datapath.
// Depends on pes_pkg.
module pes_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick_valid,
    output logic           tick_ready,
    input  pes_pkg::stat_t stat,
    output pes_pkg::cmd_t  cmd
);
    import pes_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        tick_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
                if (tick_valid)
                begin
                    cmd.op = OP_TAKE;
                    if (!stat.count_zero)
                        state_next = ST_GRAV;
                end
            end
            ST_GRAV:
            begin
                cmd.op     = OP_GRAV;
                state_next = ST_GRAVW;
            end
            ST_GRAVW:
            begin
                cmd.op     = OP_GRAVW;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = stat.spawn_hit ? ST_SPX : ST_VY;
            end
            ST_SPX:
            begin
                cmd.op     = OP_SPX;
                state_next = ST_SPY;
            end
            ST_SPY:
            begin
                cmd.op     = OP_SPY;
                state_next = ST_SPZ;
            end
            ST_SPZ:
            begin
                cmd.op     = OP_SPZ;
                state_next = ST_SPW;
            end
            ST_SPW:
            begin
                cmd.op     = OP_SPW;
                state_next = ST_VY;
            end
            ST_VY:
            begin
                cmd.op     = OP_VY;
                state_next = ST_MX;
            end
            ST_MX:
            begin
                cmd.op     = OP_MX;
                state_next = ST_MY;
            end
            ST_MY:
            begin
                cmd.op     = OP_MY;
                state_next = ST_MZ;
            end
            ST_MZ:
            begin
                cmd.op     = OP_MZ;
                state_next = ST_MW;
            end
            ST_MW:
            begin
                cmd.op     = OP_MW;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_STORE;
                    state_next = stat.last ? ST_IDLE : ST_LOAD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/core/pes_checker.sv
// Port-level checks for particle_emitter_step_top, bound to the top level.
// Depends on pes_pkg.
module pes_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           tick_ready,
    input pes_pkg::part_t part_word,
    input logic           part_valid,
    input logic           part_ready
);
    import pes_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        part_valid && !part_ready |=> part_valid && $stable(part_word))
        else $error("result word changed while stalled");

    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        part_valid |-> part_word.slot < 6'(MAX_SLOTS))
        else $error("slot beyond built size");

    a_dead: assert property (@(posedge clk) disable iff (!rst_n)
        part_valid && !part_word.alive |-> part_word.scale_out == 31'd0)
        else $error("dead particle reports a scale");

    a_walk: assert property (@(posedge clk) disable iff (!rst_n)
        part_valid && !part_word.last_slot |-> !tick_ready)
        else $error("tick offered in the middle of a walk");

endmodule

bind particle_emitter_step_top pes_checker u_pes_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_ready (tick_ready),
    .part_word  (part_word),
    .part_valid (part_valid),
    .part_ready (part_ready)
);
